// File: design/skt_pkg.sv
// skt_pkg: shared types and codes for the sorted key table
// no dependencies; imported by every design module of the block except skt_ram
package skt_pkg;

   localparam int KEY_W   = 32;
   localparam int HEAD_W  = 64;
   localparam int TAIL_W  = 8;
   localparam int ENTRY_W = KEY_W + TAIL_W + HEAD_W;

   localparam logic [1:0] OP_INSERT   = 2'd0;
   localparam logic [1:0] OP_DELETE   = 2'd1;
   localparam logic [1:0] OP_UPDATE   = 2'd2;
   localparam logic [1:0] OP_RETRIEVE = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   localparam logic [1:0] RD_IDX  = 2'd0;
   localparam logic [1:0] RD_PREV = 2'd1;
   localparam logic [1:0] RD_NEXT = 2'd2;

   localparam logic WR_NEW   = 1'b0;
   localparam logic WR_SHIFT = 1'b1;

   typedef struct packed {
      logic       load;
      logic [1:0] rd_mode;
      logic       wr_en;
      logic       wr_src;
      logic       idx_inc;
      logic       idx_dec;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       set_status;
      logic [1:0] status;
      logic       set_found;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       count_zero;
      logic       count_full;
      logic       idx_zero;
      logic       idx_one;
      logic       idx_last;
      logic       idx_next_last;
      logic       key_gt;
      logic       key_lt;
      logic       key_eq;
      logic       out_free;
   } stat_type;

endpackage

// File: design/sorted_key_table.sv
// sorted_key_table: table of up to CAPACITY entries sorted by signed key, one RAM
// the response is set without a RAM scan when the table is full or empty; otherwise after a scan and any shift
// one request at a time; every scan or shift step is a RAM read then a check
// a finished response waits in an output register while the next request is taken
// reset (synchronous, active high) clears the entry count, the index and the handshake state only
// depends on skt_pkg, skt_ctrl, skt_datapath, skt_ram
module sorted_key_table #(
   parameter int CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic signed [31:0] req_key,
   input  logic [63:0]        req_name_head,
   input  logic [7:0]         req_name_tail,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [63:0]        rsp_found_head,
   output logic [7:0]         rsp_found_tail
);
   import skt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   skt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   skt_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_operation  (req_operation),
      .req_key        (req_key),
      .req_name_head  (req_name_head),
      .req_name_tail  (req_name_tail),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_found_head (rsp_found_head),
      .rsp_found_tail (rsp_found_tail),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule

// File: design/skt_ram.sv
// skt_ram: generic single write, single read RAM with registered read data
// no dependencies
module skt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/skt_datapath.sv
// skt_datapath: request and result registers, index and count, entry RAM
// depends on skt_pkg and skt_ram
module skt_datapath #(
   parameter int CAPACITY = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           req_operation,
   input  logic signed [31:0]   req_key,
   input  logic [63:0]          req_name_head,
   input  logic [7:0]           req_name_tail,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [63:0]          rsp_found_head,
   output logic [7:0]           rsp_found_tail,
   input  skt_pkg::cmd_type     cmd,
   output skt_pkg::stat_type    stat
);
   import skt_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [1:0]         op_ff;
   logic signed [31:0] key_ff;
   logic [63:0]        head_ff;
   logic [7:0]         tail_ff;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [1:0]         status_ff;
   logic [63:0]        found_head_ff;
   logic [7:0]         found_tail_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff;
   logic [63:0]        rsp_head_ff;
   logic [7:0]         rsp_tail_ff;

   logic [CNT_W-1:0]   rd_idx;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data, wr_data;
   logic signed [31:0] rd_key;
   logic [CNT_W:0]     idx_plus1, idx_plus2, count_ext;

   always_comb begin
      unique case (cmd.rd_mode)
         RD_PREV: rd_idx = idx_ff - CNT_W'(1);
         RD_NEXT: rd_idx = idx_ff + CNT_W'(1);
         default: rd_idx = idx_ff;
      endcase
   end

   assign rd_addr = rd_idx[IDX_W-1:0];
   assign wr_data = (cmd.wr_src == WR_SHIFT) ? rd_data : {key_ff, tail_ff, head_ff};
   assign rd_key  = rd_data[ENTRY_W-1 -: KEY_W];

   skt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (idx_ff[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = (req_operation == OP_INSERT) ? count_ff : '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + CNT_W'(1);
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - CNT_W'(1);
      end
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff         <= req_operation;
         key_ff        <= req_key;
         head_ff       <= req_name_head;
         tail_ff       <= req_name_tail;
         found_head_ff <= '0;
         found_tail_ff <= '0;
      end else if (cmd.set_found) begin
         found_head_ff <= rd_data[HEAD_W-1:0];
         found_tail_ff <= rd_data[HEAD_W +: TAIL_W];
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_head_ff   <= found_head_ff;
         rsp_tail_ff   <= found_tail_ff;
      end
   end

   assign idx_plus1 = {1'b0, idx_ff} + (CNT_W+1)'(1);
   assign idx_plus2 = {1'b0, idx_ff} + (CNT_W+1)'(2);
   assign count_ext = {1'b0, count_ff};

   always_comb begin
      stat.op            = op_ff;
      stat.count_zero    = (count_ff == '0);
      stat.count_full    = (count_ff >= CNT_W'(CAPACITY));
      stat.idx_zero      = (idx_ff == '0);
      stat.idx_one       = (idx_ff == CNT_W'(1));
      stat.idx_last      = (idx_plus1 == count_ext);
      stat.idx_next_last = (idx_plus2 == count_ext);
      stat.key_gt        = (rd_key > key_ff);
      stat.key_lt        = (rd_key < key_ff);
      stat.key_eq        = (rd_key == key_ff);
      stat.out_free      = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_found_head = rsp_head_ff;
   assign rsp_found_tail = rsp_tail_ff;

endmodule

// File: design/skt_ctrl.sv
// skt_ctrl: state machine that sequences scans and shifts of the entry RAM
// depends on skt_pkg; drives skt_datapath through command and status structs
module skt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  skt_pkg::stat_type  stat,
   output skt_pkg::cmd_type   cmd
);
   import skt_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_INS_RD   = 4'd2;
   localparam logic [3:0] S_INS_CHK  = 4'd3;
   localparam logic [3:0] S_INS_PUT  = 4'd4;
   localparam logic [3:0] S_FND_RD   = 4'd5;
   localparam logic [3:0] S_FND_CHK  = 4'd6;
   localparam logic [3:0] S_DEL_RD   = 4'd7;
   localparam logic [3:0] S_DEL_CHK  = 4'd8;
   localparam logic [3:0] S_DONE     = 4'd9;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_OK;
            if (stat.op == OP_INSERT) begin
               if (stat.count_full) begin
                  cmd.status = ST_FULL;
                  state_in   = S_DONE;
               end else if (stat.idx_zero) begin
                  state_in = S_INS_PUT;
               end else begin
                  state_in = S_INS_RD;
               end
            end else if (stat.count_zero) begin
               cmd.status = ST_EMPTY;
               state_in   = S_DONE;
            end else begin
               state_in = S_FND_RD;
            end
         end
         S_INS_RD: begin
            cmd.rd_mode = RD_PREV;
            state_in    = S_INS_CHK;
         end
         S_INS_CHK: begin
            if (stat.key_gt) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_src  = WR_SHIFT;
               cmd.idx_dec = 1'b1;
               state_in    = stat.idx_one ? S_INS_PUT : S_INS_RD;
            end else begin
               state_in = S_INS_PUT;
            end
         end
         S_INS_PUT: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_src  = WR_NEW;
            cmd.cnt_inc = 1'b1;
            state_in    = S_DONE;
         end
         S_FND_RD: begin
            cmd.rd_mode = RD_IDX;
            state_in    = S_FND_CHK;
         end
         S_FND_CHK: begin
            priority if (stat.key_lt) begin
               if (stat.idx_last) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = ST_NOT_FOUND;
                  state_in       = S_DONE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_FND_RD;
               end
            end else if (stat.key_eq) begin
               unique case (stat.op)
                  OP_DELETE: begin
                     if (stat.idx_last) begin
                        cmd.cnt_dec = 1'b1;
                        state_in    = S_DONE;
                     end else begin
                        state_in = S_DEL_RD;
                     end
                  end
                  OP_UPDATE: begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_src = WR_NEW;
                     state_in   = S_DONE;
                  end
                  OP_RETRIEVE: begin
                     cmd.set_found = 1'b1;
                     state_in      = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end else begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NOT_FOUND;
               state_in       = S_DONE;
            end
         end
         S_DEL_RD: begin
            cmd.rd_mode = RD_NEXT;
            state_in    = S_DEL_CHK;
         end
         S_DEL_CHK: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_src  = WR_SHIFT;
            cmd.idx_inc = 1'b1;
            if (stat.idx_next_last) begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_DONE;
            end else begin
               state_in = S_DEL_RD;
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

// File: design/skt_checker.sv
// skt_checker: port level checks of the sorted key table over time
// depends on skt_pkg; bound to sorted_key_table below
module skt_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_status,
   input logic [63:0]        rsp_found_head,
   input logic [7:0]         rsp_found_tail
);
   import skt_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_found_head) && $stable(rsp_found_tail))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   a_name_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_found_head == '0 && rsp_found_tail == '0)
      else $error("name returned with a failing status");

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in progress");

endmodule

bind sorted_key_table skt_checker u_skt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_found_head (rsp_found_head),
   .rsp_found_tail (rsp_found_tail)
);

// File: bench/tb_top.sv
// tb_top: self-checking bench for sorted_key_table, random handshake idling on both channels
// directed table, a fill past capacity, then random insert/delete/update/retrieve mixes checked against a predictor
// depends on skt_pkg and the sorted_key_table design files
`timescale 1ns / 1ps

module tb_top;
   import skt_pkg::*;

   localparam int CAPACITY    = 64;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int TAIL_WAIT   = 2 * CAPACITY + 10;
   localparam int PHASE_ITEMS = 127;

   localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;
   localparam logic [63:0] NAME_A = 64'h0031_2d41_4c50_4841;
   localparam logic [63:0] NAME_B = 64'h0032_2d42_4554_4142;
   localparam logic [63:0] NAME_C = 64'h0033_2d43_4841_5243;
   localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

   typedef enum int {MIX_ALL, MIX_GROW, MIX_SHRINK} op_mix_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] head;
      logic [7:0]  tail;
   } lookup_rsp_type;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] key;
      logic [63:0]        head;
      logic [7:0]         tail;
      logic               fixed;
      lookup_rsp_type     want;
   } step_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_operation;
   logic signed [31:0] req_key;
   logic [63:0]        req_name_head;
   logic [7:0]         req_name_tail;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [1:0]         rsp_status;
   logic [63:0]        rsp_found_head;
   logic [7:0]         rsp_found_tail;

   logic signed [31:0] stored_keys [CAPACITY];
   logic [63:0]        stored_heads [CAPACITY];
   logic [7:0]         stored_tails [CAPACITY];
   int                 stored_count;

   lookup_rsp_type awaited_rsp [$];
   int             errors;
   int             cycle_count;
   bit             quiet;

   sorted_key_table #(
      .CAPACITY(CAPACITY)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_key(req_key),
      .req_name_head(req_name_head),
      .req_name_tail(req_name_tail),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_found_head(rsp_found_head),
      .rsp_found_tail(rsp_found_tail)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic lookup_rsp_type run_table_op(input logic [1:0] op,
                                                   input logic signed [31:0] k,
                                                   input logic [63:0] head,
                                                   input logic [7:0] tail);
      lookup_rsp_type r;
      int pos;
      r = '0;
      r.status = ST_OK;
      if (op == OP_INSERT) begin
         if (stored_count >= CAPACITY) begin
            r.status = ST_FULL;
         end else begin
            pos = 0;
            while (pos < stored_count && !(stored_keys[pos] > k)) pos++;
            for (int i = stored_count; i > pos; i--) begin
               stored_keys[i]  = stored_keys[i - 1];
               stored_heads[i] = stored_heads[i - 1];
               stored_tails[i] = stored_tails[i - 1];
            end
            stored_keys[pos]  = k;
            stored_heads[pos] = head;
            stored_tails[pos] = tail;
            stored_count++;
         end
      end else if (stored_count == 0) begin
         r.status = ST_EMPTY;
      end else begin
         pos = 0;
         while (pos < stored_count && stored_keys[pos] < k) pos++;
         if (pos >= stored_count || stored_keys[pos] != k) begin
            r.status = ST_NOT_FOUND;
         end else begin
            case (op)
               OP_DELETE: begin
                  for (int i = pos; i + 1 < stored_count; i++) begin
                     stored_keys[i]  = stored_keys[i + 1];
                     stored_heads[i] = stored_heads[i + 1];
                     stored_tails[i] = stored_tails[i + 1];
                  end
                  stored_count--;
               end
               OP_UPDATE: begin
                  stored_heads[pos] = head;
                  stored_tails[pos] = tail;
               end
               default: begin
                  r.head = stored_heads[pos];
                  r.tail = stored_tails[pos];
               end
            endcase
         end
      end
      return r;
   endfunction

   task automatic pick_request(input op_mix_type mix, output logic [1:0] op,
                               output logic signed [31:0] k, output logic [63:0] head,
                               output logic [7:0] tail);
      int roll;
      int slot;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_GROW: op = (roll < 70) ? OP_INSERT : (roll < 80) ? OP_DELETE :
                        (roll < 90) ? OP_UPDATE : OP_RETRIEVE;
         MIX_SHRINK: op = (roll < 10) ? OP_INSERT : (roll < 60) ? OP_DELETE :
                          (roll < 70) ? OP_UPDATE : OP_RETRIEVE;
         default: op = (roll < 35) ? OP_INSERT : (roll < 55) ? OP_DELETE :
                       (roll < 75) ? OP_UPDATE : OP_RETRIEVE;
      endcase
      if (op != OP_INSERT && stored_count > 0 && $urandom_range(0, 1) == 1) begin
         k = stored_keys[$urandom_range(0, stored_count - 1)];
      end else if ($urandom_range(0, 3) == 0) begin
         k = $urandom;
      end else begin
         slot = $urandom_range(0, 15);
         if (slot == 0) k = KEY_MIN;
         else if (slot == 15) k = KEY_MAX;
         else k = slot - 7;
      end
      head = {$urandom, $urandom};
      tail = 8'($urandom_range(0, 255));
   endtask

   task automatic send_request(input logic [1:0] op, input logic signed [31:0] k,
                               input logic [63:0] head, input logic [7:0] tail,
                               input logic fixed, input lookup_rsp_type want);
      lookup_rsp_type predicted;
      @(negedge clock);
      req_valid     = 1'b1;
      req_operation = op;
      req_key       = k;
      req_name_head = head;
      req_name_tail = tail;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = run_table_op(op, k, head, tail);
      awaited_rsp.push_back(fixed ? want : predicted);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 10)) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
   endtask

   initial begin
      rsp_ready = 1'b1;
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
            rsp_ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      lookup_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_rsp.size() == 0) begin
            $error("unexpected response: status %0d", rsp_status);
            errors++;
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_found_head !== want.head) begin
               $error("found_head: expected %h, actual %h", want.head, rsp_found_head);
               errors++;
            end
            if (rsp_found_tail !== want.tail) begin
               $error("found_tail: expected %h, actual %h", want.tail, rsp_found_tail);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      step_row_type       rows [26];
      logic [1:0]         op;
      logic signed [31:0] k;
      logic [63:0]        head;
      logic [7:0]         tail;
      op_mix_type         mix;

      rows = '{
         '{OP_RETRIEVE, 0, 64'h0, 8'h00, 1'b1, '{ST_EMPTY, 64'h0, 8'h00}},
         '{OP_DELETE, 5, 64'h0, 8'h00, 1'b1, '{ST_EMPTY, 64'h0, 8'h00}},
         '{OP_UPDATE, 5, 64'h1111, 8'h11, 1'b1, '{ST_EMPTY, 64'h0, 8'h00}},
         '{OP_INSERT, 100, NAME_A, 8'h41, 1'b1, '{ST_OK, 64'h0, 8'h00}},
         '{OP_RETRIEVE, 100, 64'h0, 8'h00, 1'b1, '{ST_OK, NAME_A, 8'h41}},
         '{OP_RETRIEVE, 99, 64'h0, 8'h00, 1'b1, '{ST_NOT_FOUND, 64'h0, 8'h00}},
         '{OP_INSERT, KEY_MIN, ALL_ONES, 8'hff, 1'b1, '{ST_OK, 64'h0, 8'h00}},
         '{OP_INSERT, KEY_MAX, 64'h0, 8'h00, 1'b1, '{ST_OK, 64'h0, 8'h00}},
         '{OP_RETRIEVE, KEY_MIN, 64'h0, 8'h00, 1'b1, '{ST_OK, ALL_ONES, 8'hff}},
         '{OP_RETRIEVE, KEY_MAX, ALL_ONES, 8'hff, 1'b1, '{ST_OK, 64'h0, 8'h00}},
         '{OP_INSERT, 100, NAME_B, 8'h42, 1'b0, '0},
         '{OP_RETRIEVE, 100, 64'h0, 8'h00, 1'b0, '0},
         '{OP_UPDATE, 100, NAME_C, 8'h43, 1'b0, '0},
         '{OP_RETRIEVE, 100, 64'h0, 8'h00, 1'b0, '0},
         '{OP_DELETE, 100, 64'h0, 8'h00, 1'b0, '0},
         '{OP_RETRIEVE, 100, 64'h0, 8'h00, 1'b0, '0},
         '{OP_DELETE, 100, 64'h0, 8'h00, 1'b0, '0},
         '{OP_DELETE, 100, 64'h0, 8'h00, 1'b1, '{ST_NOT_FOUND, 64'h0, 8'h00}},
         '{OP_INSERT, -1, 64'haaaa_aaaa_aaaa_aaaa, 8'h55, 1'b0, '0},
         '{OP_INSERT, 0, 64'h5555_5555_5555_5555, 8'haa, 1'b0, '0},
         '{OP_RETRIEVE, -1, 64'h0, 8'h00, 1'b0, '0},
         '{OP_DELETE, KEY_MIN, 64'h0, 8'h00, 1'b0, '0},
         '{OP_DELETE, KEY_MAX, 64'h0, 8'h00, 1'b0, '0},
         '{OP_DELETE, -1, 64'h0, 8'h00, 1'b0, '0},
         '{OP_DELETE, 0, 64'h0, 8'h00, 1'b1, '{ST_OK, 64'h0, 8'h00}},
         '{OP_RETRIEVE, 0, 64'h0, 8'h00, 1'b1, '{ST_EMPTY, 64'h0, 8'h00}}
      };

      errors        = 0;
      cycle_count   = 0;
      quiet         = 1'b0;
      stored_count  = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = OP_INSERT;
      req_key       = '0;
      req_name_head = '0;
      req_name_tail = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i])
         send_request(rows[i].op, rows[i].key, rows[i].head, rows[i].tail,
                      rows[i].fixed, rows[i].want);
      wait_drained();

      // fill past capacity so the last inserts see a full table
      repeat (CAPACITY + 3) begin
         pick_request(MIX_GROW, op, k, head, tail);
         send_request(OP_INSERT, k, head, tail, 1'b0, '0);
      end
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         quiet = (phase == 3);
         mix = (phase == 1) ? MIX_GROW : (phase == 2) ? MIX_SHRINK : MIX_ALL;
         repeat (PHASE_ITEMS) begin
            pick_request(mix, op, k, head, tail);
            send_request(op, k, head, tail, 1'b0, '0);
         end
         wait_drained();
      end

      repeat (TAIL_WAIT) @(posedge clock);
      if (errors == 0 && awaited_rsp.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
